// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/rau_pkg.sv =====
// Package: types, operation codes and controller states of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = 7;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0, FN_SUB = 3'd1, FN_MUL = 3'd2,
        FN_DIV = 3'd3, FN_LT  = 3'd4, FN_EQ  = 3'd5,
        FN_NA6 = 3'd6, FN_NA7 = 3'd7
    } t_func;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic               flag;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_FORM, S_GCD_CHK, S_GCD_DIV, S_GCD_WAIT,
        S_GSET, S_NDIV, S_NWAIT, S_DDIV, S_DWAIT, S_SIGN, S_OUT
    } t_state;

    // Datapath operation selects
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MUL1, OP_MUL2, OP_FORM, OP_GCD_START, OP_GCD_STEP,
        OP_GSET, OP_NUM_START, OP_NUM_DONE, OP_DEN_START, OP_DEN_DONE, OP_SIGN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic arith;    // operation needs reduction
        logic y_zero;   // gcd divisor term is zero
        logic g_zero;   // gcd is zero
        logic div_done;
    } t_sts;
endpackage

// ===== sv/rau_divider.sv =====
// Iterative 64-bit unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    import rau_pkg::*;
    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [63:0]       r_q, n_q, r_r, n_r, r_d, n_d;
    logic              r_done, n_done;
    logic [64:0]       w_trial;
    logic [64:0]       w_sh;

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_q = r_q; n_r = r_r; n_d = r_d;
        n_done = 1'b0;
        w_sh    = {r_r, r_q[63]};
        w_trial = w_sh - {1'b0, r_d};
        if (i_start) begin
            n_busy = 1'b1; n_cnt = '0; n_q = i_dividend; n_r = '0; n_d = i_divisor;
        end else if (r_busy) begin
            if (!w_trial[64]) begin
                n_r = w_trial[63:0];
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_r = w_sh[63:0];
                n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(63)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// ===== sv/rau_datapath.sv =====
// Datapath: products, cross terms, gcd registers, shared divider and result.
`timescale 1ns / 1ps
module rau_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rau_pkg::t_in  i_in,
    input  rau_pkg::t_cmd i_cmd,
    output rau_pkg::t_sts o_sts,
    output rau_pkg::t_out o_out
);
    import rau_pkg::*;
    localparam int OW = OPERAND_WIDTH;

    logic [2:0]         r_func;
    logic signed [31:0] r_an, r_ad, r_bn, r_bd;
    logic [63:0]        r_p0, r_p1, r_p2, r_p3;   // an*bd, ad*bn, an*bn, ad*bd
    logic [63:0]        r_num, r_den, r_x, r_y, r_g;
    logic               r_flag;
    logic               w_start;
    logic [63:0]        w_dvd, w_dvs, w_q, w_r;
    logic               w_done;
    logic signed [31:0] w_m0, w_m1;
    logic [63:0]        w_p;
    logic               w_neg_q;
    logic [63:0]        w_qs;

    function automatic logic signed [31:0] sx(input logic [31:0] v);
        sx = 32'(signed'(v[OW-1:0]));
    endfunction
    function automatic logic [63:0] mag(input logic [63:0] v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

    // Two products per step: this multiplier is shared across both steps
    always_comb begin
        w_m0 = (i_cmd.op == OP_MUL1) ? r_an : r_ad;
        w_m1 = (i_cmd.op == OP_MUL1) ? r_bd : r_bn;
        w_p  = 64'(signed'(w_m0) * signed'(w_m1));
    end

    rau_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_done(w_done), .o_quot(w_q), .o_rem(w_r)
    );

    always_comb begin
        w_start = 1'b0; w_dvd = mag(r_x); w_dvs = mag(r_y);
        unique case (i_cmd.op)
            OP_GCD_START: begin w_start = 1'b1; w_dvd = mag(r_x); w_dvs = mag(r_y); end
            OP_NUM_START: begin w_start = 1'b1; w_dvd = mag(r_num); w_dvs = mag(r_g); end
            OP_DEN_START: begin w_start = 1'b1; w_dvd = mag(r_den); w_dvs = mag(r_g); end
            default: ;
        endcase
        w_neg_q = (i_cmd.op == OP_NUM_DONE) ? (r_num[63] ^ r_g[63]) : (r_den[63] ^ r_g[63]);
        w_qs    = w_neg_q ? (64'd0 - w_q) : w_q;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_func <= i_in.func;
                r_an <= sx(i_in.a_num); r_ad <= sx(i_in.a_den);
                r_bn <= sx(i_in.b_num); r_bd <= sx(i_in.b_den);
            end
            OP_MUL1: begin
                r_p0 <= w_p;
                r_p3 <= 64'(signed'(r_ad) * signed'(r_bd));
            end
            OP_MUL2: begin
                r_p1 <= w_p;
                r_p2 <= 64'(signed'(r_an) * signed'(r_bn));
            end
            OP_FORM: begin
                unique case (t_func'(r_func))
                    FN_ADD: begin r_flag <= 1'b0; r_num <= r_p0 + r_p1; r_den <= r_p3;
                        r_x <= r_p0 + r_p1; r_y <= r_p3; end
                    FN_SUB: begin r_flag <= 1'b0; r_num <= r_p0 - r_p1; r_den <= r_p3;
                        r_x <= r_p0 - r_p1; r_y <= r_p3; end
                    FN_MUL: begin r_flag <= 1'b0; r_num <= r_p2; r_den <= r_p3;
                        r_x <= r_p2; r_y <= r_p3; end
                    FN_DIV: begin r_flag <= 1'b0; r_num <= r_p0; r_den <= r_p1;
                        r_x <= r_p0; r_y <= r_p1; end
                    FN_LT: begin
                        r_flag <= signed'(r_p0) < signed'(r_p1);
                        r_num <= '0; r_den <= '0;
                    end
                    FN_EQ: begin
                        r_flag <= (r_ad != 0) && (r_bd != 0) &&
                                  (r_ad == r_bd) && (r_an == r_bn);
                        r_num <= '0; r_den <= '0;
                    end
                    default: begin r_flag <= 1'b0; r_num <= '0; r_den <= '0; end
                endcase
            end
            OP_GCD_STEP: begin
                r_x <= r_y;
                r_y <= r_x[63] ? (64'd0 - w_r) : w_r;
            end
            OP_GSET:     r_g <= mag(r_x);
            OP_NUM_DONE: r_num <= w_qs;
            OP_DEN_DONE: r_den <= w_qs;
            OP_SIGN: if (r_den[63]) begin
                r_num <= 64'd0 - r_num; r_den <= 64'd0 - r_den;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.arith    = (r_func[2] == 1'b0);
        o_sts.y_zero   = (r_y == '0);
        o_sts.g_zero   = (r_g == '0);
        o_sts.div_done = w_done;
        o_out.res_num  = r_num;
        o_out.res_den  = r_den;
        o_out.flag     = r_flag;
    end
endmodule

// ===== sv/rau_ctrl.sv =====
// Controller state machine sequencing products, gcd loop, divisions and output.
`timescale 1ns / 1ps
module rau_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd o_cmd
);
    import rau_pkg::*;
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_valid) n_state = S_MUL1;
            S_MUL1:     n_state = S_MUL2;
            S_MUL2:     n_state = S_FORM;
            S_FORM:     n_state = i_sts.arith ? S_GCD_CHK : S_OUT;
            S_GCD_CHK:  n_state = i_sts.y_zero ? S_GSET : S_GCD_DIV;
            S_GCD_DIV:  n_state = S_GCD_WAIT;
            S_GCD_WAIT: if (i_sts.div_done) n_state = S_GCD_CHK;
            S_GSET:     n_state = S_NDIV;
            S_NDIV:     n_state = i_sts.g_zero ? S_SIGN : S_NWAIT;
            S_NWAIT:    if (i_sts.div_done) n_state = S_DDIV;
            S_DDIV:     n_state = S_DWAIT;
            S_DWAIT:    if (i_sts.div_done) n_state = S_SIGN;
            S_SIGN:     n_state = S_OUT;
            S_OUT:      if (i_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        o_ready  = (r_state == S_IDLE);
        o_valid  = (r_state == S_OUT);
        unique case (r_state)
            S_IDLE:     if (i_valid) o_cmd.op = OP_LOAD;
            S_MUL1:     o_cmd.op = OP_MUL1;
            S_MUL2:     o_cmd.op = OP_MUL2;
            S_FORM:     o_cmd.op = OP_FORM;
            S_GCD_DIV:  o_cmd.op = OP_GCD_START;
            S_GCD_WAIT: if (i_sts.div_done) o_cmd.op = OP_GCD_STEP;
            S_GSET:     o_cmd.op = OP_GSET;
            S_NDIV:     if (!i_sts.g_zero) o_cmd.op = OP_NUM_START;
            S_NWAIT:    if (i_sts.div_done) o_cmd.op = OP_NUM_DONE;
            S_DDIV:     o_cmd.op = OP_DEN_START;
            S_DWAIT:    if (i_sts.div_done) o_cmd.op = OP_DEN_DONE;
            S_SIGN:     o_cmd.op = OP_SIGN;
            default:    ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: controller plus datapath.
// One transaction at a time. Products are formed in states MUL1 and MUL2,
// then the Euclidean gcd runs on one shared restoring divider, each
// remainder step passing through check, start, the busy divider and done,
// followed by two more divisions on the same divider for the reduction.
// When the gcd is zero both divisions are skipped; compares skip the gcd
// and the divisions. The shared divider dominates the time to a result.
// Input ready is high only while idle; the result holds in output
// registers until taken.
`timescale 1ns / 1ps
module rational_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rau_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rau_pkg::t_out o_data
);
    import rau_pkg::*;
    t_cmd w_cmd;
    t_sts w_sts;

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    rau_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_data), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_out(o_data)
    );
endmodule

// ===== sv/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input rau_pkg::t_out o_data
);
    import rau_pkg::*;
    `CHK_IMPL(a_excl, i_clk, i_rst_n, o_valid, !o_ready, "ready while result pending")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "result dropped")
    `CHK_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "accepted twice")
    `CHK_IMPL(a_den, i_clk, i_rst_n, o_valid && o_data.flag, o_data.res_den == 64'd0, "flag with fraction")
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
